// ===== rtl/detector_word_timestamp_decoder_top_assert.svh =====
// assertion macros for the timestamp decoder checker
`ifndef DETECTOR_WORD_TIMESTAMP_DECODER_TOP_ASSERT_SVH
`define DETECTOR_WORD_TIMESTAMP_DECODER_TOP_ASSERT_SVH

// antecedent and consequent in the same cycle
`define DWTD_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("dwtd check failed");

// consequent in the cycle after the antecedent
`define DWTD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("dwtd check failed");

`endif

// ===== rtl/dwtd_pkg.sv =====
// shared types, constants and helpers of the timestamp decoder
`timescale 1ns / 1ps
`default_nettype none

package dwtd_pkg;

    localparam int FEE_COUNT     = 64;
    localparam int ASICS_PER_FEE = 4;
    localparam int TABLE_SIZE    = FEE_COUNT * ASICS_PER_FEE;
    localparam int IDX_W         = (TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam int DELTA_W = 24;
    localparam int COUNT_W = 16;
    localparam int PADDR_W = 4;

    localparam logic [1:0] KIND_ADC     = 2'd0;
    localparam logic [1:0] KIND_INFO    = 2'd1;
    localparam logic [1:0] KIND_SYNC    = 2'd2;
    localparam logic [1:0] KIND_UNKNOWN = 2'd3;

    localparam logic [1:0] REG_INCLUDE_SYNC  = 2'd0;
    localparam logic [1:0] REG_DELTA_CEILING = 2'd1;
    localparam logic [1:0] REG_WINDOW_LOW    = 2'd2;
    localparam logic [1:0] REG_WINDOW_HIGH   = 2'd3;

    localparam logic [31:0] SYNC_MASK  = 32'hC0F0_0000;
    localparam logic [31:0] SYNC_CODE  = 32'h8050_0000;
    localparam logic [31:0] CLASS_MASK = 32'hC000_0000;
    localparam logic [31:0] ADC_CODE   = 32'hC000_0000;
    localparam logic [31:0] INFO_CODE  = 32'h8000_0000;

    localparam logic [DELTA_W-1:0] DELTA_CEILING_RST = 24'd999999;
    localparam logic [DELTA_W-1:0] WINDOW_LOW_RST    = 24'd1990;
    localparam logic [DELTA_W-1:0] WINDOW_HIGH_RST   = 24'd2010;
    localparam logic [COUNT_W-1:0] COUNT_MAX         = 16'hFFFF;

    typedef struct packed {
        logic        command;
        logic [31:0] det_word;
        logic [27:0] low_word;
        logic [63:0] base_time;
    } in_t;

    typedef struct packed {
        logic [1:0]         kind;
        logic [63:0]        timestamp;
        logic [31:0]        raw_word;
        logic [DELTA_W-1:0] global_delta;
        logic [6:0]         fee_number;
        logic [5:0]         channel;
        logic               veto_range;
        logic [15:0]        adc_value;
        logic [DELTA_W-1:0] asic_delta;
        logic [COUNT_W-1:0] multiplex_count;
        logic [3:0]         info_code;
        logic [19:0]        info_field;
    } out_t;

    typedef struct packed {
        logic               include_sync;
        logic [DELTA_W-1:0] delta_ceiling;
        logic [DELTA_W-1:0] window_low;
        logic [DELTA_W-1:0] window_high;
    } cfg_t;

    typedef struct packed {
        out_t             res;
        logic             is_adc;
        logic [IDX_W-1:0] idx;
    } job_t;

    // wrapping difference clipped to the ceiling
    function automatic logic [DELTA_W-1:0] sat_delta(input logic [63:0]        now_t,
                                                     input logic [63:0]        prev_t,
                                                     input logic [DELTA_W-1:0] ceiling);
        logic [63:0] diff;
        diff = now_t - prev_t;
        if (diff > {{(64-DELTA_W){1'b0}}, ceiling})
        begin
            return ceiling;
        end
        return diff[DELTA_W-1:0];
    endfunction

endpackage

`default_nettype wire

// ===== rtl/dwtd_cfg.sv =====
// configuration registers behind the apb-style port
`timescale 1ns / 1ps
`default_nettype none

module dwtd_cfg
    import dwtd_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [31:0]        pwdata,
    output logic [31:0]             prdata,
    output logic                    pready,
    output cfg_t                    cfg
);

    cfg_t cfg_reg;
    logic wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite & pready;
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.include_sync  <= 1'b0;
            cfg_reg.delta_ceiling <= DELTA_CEILING_RST;
            cfg_reg.window_low    <= WINDOW_LOW_RST;
            cfg_reg.window_high   <= WINDOW_HIGH_RST;
        end
        else if (wr_en)
        begin
            unique case (paddr[3:2])
                REG_INCLUDE_SYNC:  cfg_reg.include_sync  <= pwdata[0];
                REG_DELTA_CEILING: cfg_reg.delta_ceiling <= pwdata[DELTA_W-1:0];
                REG_WINDOW_LOW:    cfg_reg.window_low    <= pwdata[DELTA_W-1:0];
                REG_WINDOW_HIGH:   cfg_reg.window_high   <= pwdata[DELTA_W-1:0];
                default:           cfg_reg <= cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            REG_INCLUDE_SYNC:  prdata = {31'd0, cfg_reg.include_sync};
            REG_DELTA_CEILING: prdata = {{(32-DELTA_W){1'b0}}, cfg_reg.delta_ceiling};
            REG_WINDOW_LOW:    prdata = {{(32-DELTA_W){1'b0}}, cfg_reg.window_low};
            REG_WINDOW_HIGH:   prdata = {{(32-DELTA_W){1'b0}}, cfg_reg.window_high};
            default:           prdata = '0;
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/dwtd_front.sv =====
// front end: accepts beats, tracks running time and classifies words
`timescale 1ns / 1ps
`default_nettype none

module dwtd_front
    import dwtd_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic item_valid,
    output logic      item_ready,
    input  wire in_t  item,
    input  wire cfg_t cfg,
    input  wire logic q_full,
    output logic      push,
    output job_t      push_job
);

    logic [63:0] cur_time_reg, cur_time_next;
    logic        await_reg, await_next;
    logic [15:0] high_reg, high_next;
    logic        accept;
    logic        emit;
    logic [31:0] word;
    logic [63:0] ts;
    logic [5:0]  fee;
    logic [5:0]  chan;
    logic [1:0]  asic;
    logic [5:0]  fee_sat;
    logic [1:0]  asic_sat;

    assign item_ready = !q_full;
    assign accept     = item_valid & item_ready;
    assign push       = accept & emit;

    assign word = item.det_word;
    assign ts   = {cur_time_reg[63:28], item.low_word};
    assign fee  = word[27:22];
    assign chan = word[21:16];
    assign asic = chan[5:4];

    always_comb
    begin
        fee_sat  = (int'(fee) < FEE_COUNT) ? fee : 6'(FEE_COUNT - 1);
        asic_sat = (int'(asic) < ASICS_PER_FEE) ? asic : 2'(ASICS_PER_FEE - 1);
    end

    always_comb
    begin
        cur_time_next = cur_time_reg;
        await_next    = await_reg;
        high_next     = high_reg;
        emit          = 1'b0;
        push_job                = '0;
        push_job.res.timestamp  = ts;
        push_job.res.raw_word   = word;
        if (!item.command)
        begin
            cur_time_next = item.base_time;
            await_next    = 1'b0;
        end
        else if (await_reg)
        begin
            // middle word of a sync pair, only the low 16 high bits survive the shift
            emit                    = cfg.include_sync;
            push_job.res.kind       = KIND_SYNC;
            push_job.res.info_code  = word[23:20];
            push_job.res.info_field = word[19:0];
            cur_time_next           = {high_reg, word[19:0], item.low_word};
            await_next              = 1'b0;
        end
        else if ((word & SYNC_MASK) == SYNC_CODE)
        begin
            emit                    = cfg.include_sync;
            push_job.res.kind       = KIND_SYNC;
            push_job.res.info_code  = word[23:20];
            push_job.res.info_field = word[19:0];
            high_next               = word[15:0];
            await_next              = 1'b1;
        end
        else if ((word & CLASS_MASK) == ADC_CODE)
        begin
            emit                    = 1'b1;
            push_job.res.kind       = KIND_ADC;
            push_job.res.fee_number = {1'b0, fee} + 7'd1;
            push_job.res.channel    = chan;
            push_job.res.veto_range = word[28];
            push_job.res.adc_value  = word[15:0];
            push_job.is_adc         = 1'b1;
            push_job.idx            = IDX_W'(int'(fee_sat) * ASICS_PER_FEE + int'(asic_sat));
        end
        else if ((word & CLASS_MASK) == INFO_CODE)
        begin
            emit                    = 1'b1;
            push_job.res.kind       = KIND_INFO;
            push_job.res.fee_number = {1'b0, word[29:24]} + 7'd1;
            push_job.res.info_code  = word[23:20];
            push_job.res.info_field = word[19:0];
        end
        else
        begin
            emit              = 1'b1;
            push_job.res.kind = KIND_UNKNOWN;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_time_reg <= '0;
            await_reg    <= 1'b0;
            high_reg     <= '0;
        end
        else if (accept)
        begin
            cur_time_reg <= cur_time_next;
            await_reg    <= await_next;
            high_reg     <= high_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/dwtd_queue.sv =====
// short job queue between front and back
`timescale 1ns / 1ps
`default_nettype none

module dwtd_queue
    import dwtd_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    input  wire job_t push_job,
    input  wire logic pop,
    output job_t      head,
    output logic      empty,
    output logic      full
);

    job_t              slots [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic              do_pop;

    assign empty  = (count_reg == '0);
    assign full   = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign head   = slots[rd_ptr_reg];
    assign do_pop = pop & !empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        case ({push, do_pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slots[wr_ptr_reg] <= push_job;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/dwtd_back.sv =====
// back end: global delta, per-asic table update and result register
`timescale 1ns / 1ps
`default_nettype none

module dwtd_back
    import dwtd_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire cfg_t cfg,
    input  wire job_t head,
    input  wire logic q_empty,
    output logic      pop,
    output logic      result_valid,
    input  wire logic result_ready,
    output out_t      result
);

    logic [63:0]        last_time_mem [TABLE_SIZE];
    logic [COUNT_W-1:0] run_count_mem [TABLE_SIZE];
    // one written bit per asic covers both tables; a count write still in
    // flight is always caught by the forwarding path
    logic [TABLE_SIZE-1:0] last_vld_reg;

    logic               adv;
    logic               s2_write;
    logic [63:0]        prev_time_reg;
    job_t               head_gd;

    logic               s1_valid_reg;
    job_t               s1_job_reg;
    logic [63:0]        s1_last_reg;
    logic               s1_last_vld_reg;
    logic [COUNT_W-1:0] s1_cnt_reg;

    logic               s2_valid_reg;
    job_t               s2_job_reg;
    logic [DELTA_W-1:0] s2_ad_reg;
    logic [COUNT_W-1:0] s2_cnt_reg;
    logic               s2_cnt_vld_reg;

    // last two count writes, covering the gap between table read and write
    logic               h1_vld_reg, h2_vld_reg;
    logic [IDX_W-1:0]   h1_idx_reg, h2_idx_reg;
    logic [COUNT_W-1:0] h1_cnt_reg, h2_cnt_reg;

    logic [COUNT_W-1:0] old_cnt;
    logic [COUNT_W-1:0] cnt_new;
    logic               in_window;

    out_t               result_reg;
    logic               result_valid_reg;

    assign adv          = !result_valid_reg || result_ready;
    assign pop          = adv && !q_empty;
    assign s2_write     = adv && s2_valid_reg && s2_job_reg.is_adc;
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    always_comb
    begin
        head_gd = head;
        head_gd.res.global_delta = sat_delta(head.res.timestamp, prev_time_reg,
                                             cfg.delta_ceiling);
    end

    // last time table: read old value and write new one in the same beat
    always_ff @(posedge clk)
    begin
        if (pop && head.is_adc)
        begin
            s1_last_reg              <= last_time_mem[head.idx];
            last_time_mem[head.idx]  <= head.res.timestamp;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop && head.is_adc)
        begin
            s1_cnt_reg <= run_count_mem[head.idx];
        end
        if (s2_write)
        begin
            run_count_mem[s2_job_reg.idx] <= cnt_new;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_vld_reg    <= '0;
            s1_last_vld_reg <= 1'b0;
        end
        else
        begin
            if (pop && head.is_adc)
            begin
                s1_last_vld_reg        <= last_vld_reg[head.idx];
                last_vld_reg[head.idx] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_time_reg    <= '0;
            s1_valid_reg     <= 1'b0;
            s2_valid_reg     <= 1'b0;
            result_valid_reg <= 1'b0;
            h1_vld_reg       <= 1'b0;
            h2_vld_reg       <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg     <= pop;
            s2_valid_reg     <= s1_valid_reg;
            result_valid_reg <= s2_valid_reg;
            if (pop)
            begin
                prev_time_reg <= head.res.timestamp;
            end
            if (s2_write)
            begin
                h1_vld_reg <= 1'b1;
                h2_vld_reg <= h1_vld_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            if (pop)
            begin
                s1_job_reg <= head_gd;
            end
            if (s1_valid_reg)
            begin
                s2_job_reg     <= s1_job_reg;
                s2_ad_reg      <= sat_delta(s1_job_reg.res.timestamp,
                                            s1_last_vld_reg ? s1_last_reg : 64'd0,
                                            cfg.delta_ceiling);
                s2_cnt_reg     <= s1_cnt_reg;
                s2_cnt_vld_reg <= s1_last_vld_reg;
            end
            if (s2_valid_reg)
            begin
                result_reg <= s2_job_reg.res;
                if (s2_job_reg.is_adc)
                begin
                    result_reg.asic_delta      <= s2_ad_reg;
                    result_reg.multiplex_count <= cnt_new;
                end
            end
            if (s2_write)
            begin
                h1_idx_reg <= s2_job_reg.idx;
                h1_cnt_reg <= cnt_new;
                h2_idx_reg <= h1_idx_reg;
                h2_cnt_reg <= h1_cnt_reg;
            end
        end
    end

    always_comb
    begin
        if (h1_vld_reg && h1_idx_reg == s2_job_reg.idx)
        begin
            old_cnt = h1_cnt_reg;
        end
        else if (h2_vld_reg && h2_idx_reg == s2_job_reg.idx)
        begin
            old_cnt = h2_cnt_reg;
        end
        else
        begin
            old_cnt = s2_cnt_vld_reg ? s2_cnt_reg : '0;
        end
        in_window = (s2_ad_reg >= cfg.window_low) && (s2_ad_reg <= cfg.window_high);
        if (!in_window)
        begin
            cnt_new = '0;
        end
        else if (old_cnt == COUNT_MAX)
        begin
            cnt_new = COUNT_MAX;
        end
        else
        begin
            cnt_new = old_cnt + 1'b1;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/detector_word_timestamp_decoder_top.sv =====
// an accepted word beat passes the job queue, stages s1 and s2 and the result register
// throughput: one beat per cycle while the queue is not full; last times are read and
// rewritten at dequeue, counts are written two stages later with the last two count writes forwarded
// words that give no result (base loads, hidden sync pairs) never enter the queue
// reset: asynchronous, active low; clears running time, registers and table valid bits
`timescale 1ns / 1ps
`default_nettype none

module detector_word_timestamp_decoder_top
    import dwtd_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [31:0]        pwdata,
    output logic [31:0]             prdata,
    output logic                    pready,
    input  wire logic               item_valid,
    output logic                    item_ready,
    input  wire in_t                item,
    output logic                    result_valid,
    input  wire logic               result_ready,
    output out_t                    result
);

    cfg_t cfg;
    logic q_full;
    logic q_empty;
    logic push;
    logic pop;
    job_t push_job;
    job_t head;

    dwtd_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    dwtd_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item       (item),
        .cfg        (cfg),
        .q_full     (q_full),
        .push       (push),
        .push_job   (push_job)
    );

    dwtd_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .head     (head),
        .empty    (q_empty),
        .full     (q_full)
    );

    dwtd_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .head         (head),
        .q_empty      (q_empty),
        .pop          (pop),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

endmodule

`default_nettype wire

// ===== rtl/dwtd_checker.sv =====
// port-level checks of the timestamp decoder and their bind
`timescale 1ns / 1ps
`include "detector_word_timestamp_decoder_top_assert.svh"
`default_nettype none

module dwtd_checker
    import dwtd_pkg::*;
(
    input wire logic clk,
    input wire logic rst_n,
    input wire logic pready,
    input wire logic result_valid,
    input wire logic result_ready,
    input wire out_t result
);

    logic adc_fields_zero;

    assign adc_fields_zero = (result.asic_delta == '0) && (result.multiplex_count == '0)
                             && (result.channel == '0);

    `DWTD_ASSERT_SAME(a_pready_high, 1'b1, pready)

    `DWTD_ASSERT_NEXT(a_result_hold, result_valid && !result_ready, result_valid && $stable(result))

    `DWTD_ASSERT_SAME(a_adc_fee, result_valid && result.kind == KIND_ADC, result.fee_number != 7'd0)

    `DWTD_ASSERT_SAME(a_non_adc_clean, result_valid && result.kind != KIND_ADC, adc_fields_zero)

endmodule

bind detector_word_timestamp_decoder_top dwtd_checker u_dwtd_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .pready       (pready),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
);

`default_nettype wire

// ===== dv/detector_word_timestamp_decoder_top_tb.sv =====
// self-checking testbench of the detector word timestamp decoder: directed table then random traffic
`timescale 1ns / 1ps

module detector_word_timestamp_decoder_top_tb;
    import dwtd_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 8;

    typedef struct {
        bit          is_reg;
        logic [1:0]  reg_idx;
        logic [31:0] reg_val;
        in_t         beat;
        bit          typed;
        out_t        want;
    } stim_row_t;

    logic               clk = 1'b0;
    logic               rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [31:0]        pwdata;
    logic [31:0]        prdata;
    logic               pready;
    logic               item_valid;
    logic               item_ready;
    in_t                item;
    logic               result_valid;
    logic               result_ready;
    out_t               result;

    // running copy of the decoder state
    logic [63:0]        run_time;
    logic [63:0]        last_result_time;
    logic               mid_pending;
    logic [19:0]        sync_high;
    logic [63:0]        asic_time [TABLE_SIZE];
    logic [COUNT_W-1:0] asic_run [TABLE_SIZE];
    logic               cfg_sync;
    logic [DELTA_W-1:0] cfg_ceiling;
    logic [DELTA_W-1:0] cfg_win_lo;
    logic [DELTA_W-1:0] cfg_win_hi;

    out_t      pending_results[$];
    stim_row_t dir_rows[$];
    int        mismatches = 0;
    int        cycles = 0;
    int        gap_pct = 0;
    int        stall_pct = 0;
    int        beats_sent = 0;

    detector_word_timestamp_decoder_top u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("detector_word_timestamp_decoder_top_tb NOT OK");
            $finish;
        end
    end

    always @(negedge clk)
        result_ready <= ($urandom_range(99) >= stall_pct);

    task automatic note_mismatch(input string what);
        mismatches++;
        if (mismatches <= 10)
            $display("mismatch at %0t ns:%s", $time, what);
    endtask

    function automatic string field_diffs(input out_t e, input out_t g);
        string s;
        s = "";
        if (g.kind !== e.kind)
            s = {s, $sformatf(" kind exp %0d got %0d", e.kind, g.kind)};
        if (g.timestamp !== e.timestamp)
            s = {s, $sformatf(" timestamp exp %h got %h", e.timestamp, g.timestamp)};
        if (g.raw_word !== e.raw_word)
            s = {s, $sformatf(" raw_word exp %h got %h", e.raw_word, g.raw_word)};
        if (g.global_delta !== e.global_delta)
            s = {s, $sformatf(" global_delta exp %0d got %0d", e.global_delta, g.global_delta)};
        if (g.fee_number !== e.fee_number)
            s = {s, $sformatf(" fee_number exp %0d got %0d", e.fee_number, g.fee_number)};
        if (g.channel !== e.channel)
            s = {s, $sformatf(" channel exp %0d got %0d", e.channel, g.channel)};
        if (g.veto_range !== e.veto_range)
            s = {s, $sformatf(" veto_range exp %0d got %0d", e.veto_range, g.veto_range)};
        if (g.adc_value !== e.adc_value)
            s = {s, $sformatf(" adc_value exp %h got %h", e.adc_value, g.adc_value)};
        if (g.asic_delta !== e.asic_delta)
            s = {s, $sformatf(" asic_delta exp %0d got %0d", e.asic_delta, g.asic_delta)};
        if (g.multiplex_count !== e.multiplex_count)
            s = {s, $sformatf(" multiplex_count exp %0d got %0d",
                              e.multiplex_count, g.multiplex_count)};
        if (g.info_code !== e.info_code)
            s = {s, $sformatf(" info_code exp %h got %h", e.info_code, g.info_code)};
        if (g.info_field !== e.info_field)
            s = {s, $sformatf(" info_field exp %h got %h", e.info_field, g.info_field)};
        return s;
    endfunction

    always @(posedge clk)
    begin : result_check
        out_t  want;
        string diffs;
        if (rst_n && result_valid && result_ready)
        begin
            if (pending_results.size() == 0)
            begin
                note_mismatch($sformatf(" unexpected result %h", result));
            end
            else
            begin
                want = pending_results.pop_front();
                diffs = field_diffs(want, result);
                if (diffs != "")
                    note_mismatch(diffs);
            end
        end
    end

    function automatic logic [DELTA_W-1:0] clip_delta(input logic [63:0] later,
                                                       input logic [63:0] earlier);
        logic [63:0] span;
        span = later - earlier;
        return (span > 64'(cfg_ceiling)) ? cfg_ceiling : span[DELTA_W-1:0];
    endfunction

    task automatic open_result(input logic [1:0] kind, input logic [63:0] stamp,
                               input logic [31:0] word, output out_t r);
        r = '0;
        r.kind = kind;
        r.timestamp = stamp;
        r.raw_word = word;
        r.global_delta = clip_delta(stamp, last_result_time);
        last_result_time = stamp;
    endtask

    task automatic decode_word(input in_t b, output bit fires, output out_t r);
        logic [63:0]        stamp;
        logic [31:0]        word;
        logic [IDX_W-1:0]   slot;
        logic [DELTA_W-1:0] ad;
        fires = 1'b0;
        r = '0;
        word = b.det_word;
        stamp = {run_time[63:28], b.low_word};
        if (!b.command)
        begin
            run_time = b.base_time;
            mid_pending = 1'b0;
        end
        else if (mid_pending || (word & SYNC_MASK) == SYNC_CODE)
        begin
            if (cfg_sync)
            begin
                open_result(KIND_SYNC, stamp, word, r);
                r.info_code = word[23:20];
                r.info_field = word[19:0];
                fires = 1'b1;
            end
            // middle word: its own stamp still uses the old running time
            if (mid_pending)
            begin
                run_time = {sync_high[15:0], word[19:0], b.low_word};
                mid_pending = 1'b0;
            end
            else
            begin
                sync_high = word[19:0];
                mid_pending = 1'b1;
            end
        end
        else if ((word & CLASS_MASK) == ADC_CODE)
        begin
            slot = {word[27:22], word[21:20]};
            open_result(KIND_ADC, stamp, word, r);
            r.fee_number = 7'(word[27:22]) + 7'd1;
            r.channel = word[21:16];
            r.veto_range = word[28];
            r.adc_value = word[15:0];
            ad = clip_delta(stamp, asic_time[slot]);
            asic_time[slot] = stamp;
            if (ad >= cfg_win_lo && ad <= cfg_win_hi)
            begin
                if (asic_run[slot] != COUNT_MAX)
                    asic_run[slot] = asic_run[slot] + 1'b1;
            end
            else
            begin
                asic_run[slot] = '0;
            end
            r.asic_delta = ad;
            r.multiplex_count = asic_run[slot];
            fires = 1'b1;
        end
        else if ((word & CLASS_MASK) == INFO_CODE)
        begin
            open_result(KIND_INFO, stamp, word, r);
            r.fee_number = 7'(word[29:24]) + 7'd1;
            r.info_code = word[23:20];
            r.info_field = word[19:0];
            fires = 1'b1;
        end
        else
        begin
            open_result(KIND_UNKNOWN, stamp, word, r);
            fires = 1'b1;
        end
    endtask

    function automatic in_t word_beat(input logic [31:0] word, input logic [27:0] low);
        in_t b;
        b.command = 1'b1;
        b.det_word = word;
        b.low_word = low;
        b.base_time = {$urandom, $urandom};
        return b;
    endfunction

    function automatic in_t base_beat(input logic [63:0] t);
        in_t b;
        b.command = 1'b0;
        b.det_word = $urandom;
        b.low_word = 28'($urandom);
        b.base_time = t;
        return b;
    endfunction

    function automatic stim_row_t beat_row(input in_t b, input bit typed = 1'b0,
                                           input out_t want = '0);
        stim_row_t r;
        r.is_reg = 1'b0;
        r.reg_idx = '0;
        r.reg_val = '0;
        r.beat = b;
        r.typed = typed;
        r.want = want;
        return r;
    endfunction

    function automatic stim_row_t reg_row(input logic [1:0] idx, input logic [31:0] value);
        stim_row_t r;
        r.is_reg = 1'b1;
        r.reg_idx = idx;
        r.reg_val = value;
        r.beat = '0;
        r.typed = 1'b0;
        r.want = '0;
        return r;
    endfunction

    task automatic add_row(input stim_row_t r);
        dir_rows.insert(dir_rows.size(), r);
    endtask

    // called at a falling edge, returns at the falling edge after acceptance
    task automatic send_beat(input in_t b, input bit typed = 1'b0, input out_t want = '0);
        bit   fires;
        out_t r;
        while ($urandom_range(99) < gap_pct)
        begin
            item_valid <= 1'b0;
            @(negedge clk);
        end
        item_valid <= 1'b1;
        item <= b;
        @(posedge clk);
        while (!item_ready)
            @(posedge clk);
        decode_word(b, fires, r);
        if (fires)
            pending_results.insert(pending_results.size(), typed ? want : r);
        beats_sent++;
        @(negedge clk);
    endtask

    task automatic settle();
        item_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
        logic [31:0] readback;
        logic [31:0] held;
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= PADDR_W'({idx, 2'b00});
        pwdata <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        case (idx)
            REG_INCLUDE_SYNC:  cfg_sync = value[0];
            REG_DELTA_CEILING: cfg_ceiling = value[DELTA_W-1:0];
            REG_WINDOW_LOW:    cfg_win_lo = value[DELTA_W-1:0];
            default:           cfg_win_hi = value[DELTA_W-1:0];
        endcase
        @(negedge clk);
        // read it straight back
        pwrite <= 1'b0;
        penable <= 1'b0;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        readback = prdata;
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        case (idx)
            REG_INCLUDE_SYNC:  held = 32'(cfg_sync);
            REG_DELTA_CEILING: held = 32'(cfg_ceiling);
            REG_WINDOW_LOW:    held = 32'(cfg_win_lo);
            default:           held = 32'(cfg_win_hi);
        endcase
        if (readback !== held)
            note_mismatch($sformatf(" register %0d read exp %h got %h", idx, held, readback));
    endtask

    task automatic configure(input logic sync, input logic [DELTA_W-1:0] ceiling,
                             input logic [DELTA_W-1:0] lo, input logic [DELTA_W-1:0] hi);
        write_reg(REG_INCLUDE_SYNC, 32'(sync));
        write_reg(REG_DELTA_CEILING, 32'(ceiling));
        write_reg(REG_WINDOW_LOW, 32'(lo));
        write_reg(REG_WINDOW_HIGH, 32'(hi));
    endtask

    task automatic random_group();
        int          pick;
        int          step;
        logic [5:0]  fee;
        logic [1:0]  asic;
        logic [27:0] low;
        logic [63:0] t;
        in_t         b;
        pick = $urandom_range(99);
        if (pick < 5)
        begin
            case ($urandom_range(3))
                0:       t = '0;
                1:       t = '1;
                default: t = {$urandom, $urandom};
            endcase
            send_beat(base_beat(t));
        end
        else if (pick < 17)
        begin
            // sync pair, now and then broken by a base load
            send_beat(word_beat({2'b10, 6'($urandom), 4'h5, 20'($urandom)}, 28'($urandom)));
            if ($urandom_range(9) == 0)
                send_beat(base_beat({$urandom, $urandom}));
            send_beat(word_beat($urandom, 28'($urandom)));
        end
        else if (pick < 57)
        begin
            // run of adc words on one asic, stepping around the multiplex window
            fee = 6'($urandom);
            asic = 2'($urandom);
            low = 28'($urandom);
            repeat ($urandom_range(6, 1))
            begin
                if ($urandom_range(9) == 0)
                    step = $urandom_range(1 << 24);
                else
                    step = $urandom_range(int'(cfg_win_hi) + 3,
                                          (cfg_win_lo > 3) ? int'(cfg_win_lo) - 3 : 0);
                low = low + 28'(step);
                send_beat(word_beat({2'b11, 1'($urandom), 1'($urandom), fee, asic,
                                     4'($urandom), 16'($urandom)}, low));
            end
        end
        else if (pick < 72)
        begin
            send_beat(word_beat({2'b10, 30'($urandom)}, 28'($urandom)));
        end
        else if (pick < 82)
        begin
            send_beat(word_beat({1'b0, 31'($urandom)}, 28'($urandom)));
        end
        else
        begin
            b = word_beat($urandom, 28'($urandom));
            b.command = 1'($urandom);
            send_beat(b);
        end
    endtask

    task automatic run_phase(input int beats, input int gap, input int stall);
        int target;
        gap_pct = gap;
        stall_pct = stall;
        target = beats_sent + beats;
        while (beats_sent < target)
            random_group();
        settle();
    endtask

    initial
    begin
        logic [DELTA_W-1:0] lo;
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        item_valid = 1'b0;
        item = '0;
        result_ready = 1'b0;

        run_time = '0;
        last_result_time = '0;
        mid_pending = 1'b0;
        sync_high = '0;
        foreach (asic_time[i])
        begin
            asic_time[i] = '0;
            asic_run[i] = '0;
        end
        cfg_sync = 1'b0;
        cfg_ceiling = DELTA_CEILING_RST;
        cfg_win_lo = WINDOW_LOW_RST;
        cfg_win_hi = WINDOW_HIGH_RST;

        // straight after reset with default registers
        add_row(beat_row(word_beat(32'h0000_0000, 28'h000_0000), 1'b1,
            out_t'{KIND_UNKNOWN, 64'd0, 32'd0, 24'd0, 7'd0, 6'd0, 1'b0, 16'd0,
                   24'd0, 16'd0, 4'd0, 20'd0}));
        add_row(beat_row(base_beat(64'hFFFF_FFFF_FFFF_FFFF)));
        add_row(beat_row(word_beat(32'hFFFF_FFFF, 28'hFFF_FFFF), 1'b1,
            out_t'{KIND_ADC, 64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF, 24'd999999, 7'd64,
                   6'd63, 1'b1, 16'hFFFF, 24'd999999, 16'd0, 4'd0, 20'd0}));
        // time runs backwards here
        add_row(beat_row(word_beat(32'hBFFF_FFFF, 28'h000_0000), 1'b1,
            out_t'{KIND_INFO, 64'hFFFF_FFFF_F000_0000, 32'hBFFF_FFFF, 24'd999999, 7'd64,
                   6'd0, 1'b0, 16'd0, 24'd0, 16'd0, 4'hF, 20'hFFFFF}));
        add_row(beat_row(base_beat(64'd0)));
        // window edges on one asic
        add_row(beat_row(word_beat(32'hC000_0000, 28'd1990)));
        add_row(beat_row(word_beat(32'hC000_ABCD, 28'd4000)));
        add_row(beat_row(word_beat(32'hC000_0000, 28'd6011)));
        add_row(beat_row(word_beat(32'hC00F_0000, 28'd8000)));
        add_row(beat_row(word_beat(32'h8000_0000, 28'd9000)));
        add_row(beat_row(word_beat(32'h4000_0000, 28'd9001)));
        // hidden sync pair rebuilds the running time
        add_row(beat_row(word_beat(32'h805A_BCDE, 28'd9002)));
        add_row(beat_row(word_beat(32'h0001_2345, 28'h000_0100)));
        add_row(beat_row(word_beat(32'hD140_0001, 28'h000_0200)));
        add_row(reg_row(REG_INCLUDE_SYNC, 32'd1));
        add_row(beat_row(word_beat(32'hBF5F_FFFF, 28'd5)));
        add_row(beat_row(word_beat(32'hFFFF_FFFF, 28'hFFF_FFFF)));
        // base load cancels a pending middle word
        add_row(beat_row(word_beat(32'h8050_0000, 28'd7)));
        add_row(beat_row(base_beat(64'h0123_4567_89AB_CDEF)));
        add_row(beat_row(word_beat(32'h0050_0000, 28'd3)));
        // middle word that looks like a marker itself
        add_row(beat_row(word_beat(32'h8050_0000, 28'd11)));
        add_row(beat_row(word_beat(32'h8051_2345, 28'd12)));
        add_row(reg_row(REG_DELTA_CEILING, 32'd0));
        add_row(beat_row(word_beat(32'hC3F3_0000, 28'd100)));
        add_row(reg_row(REG_DELTA_CEILING, 32'h00FF_FFFF));
        add_row(reg_row(REG_WINDOW_LOW, 32'd0));
        add_row(reg_row(REG_WINDOW_HIGH, 32'h00FF_FFFF));
        add_row(beat_row(word_beat(32'hC3F3_1111, 28'd5000)));
        add_row(beat_row(word_beat(32'hBE9F_0F0F, 28'd5001)));

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (dir_rows[i])
        begin
            if (dir_rows[i].is_reg)
            begin
                settle();
                write_reg(dir_rows[i].reg_idx, dir_rows[i].reg_val);
            end
            else
            begin
                send_beat(dir_rows[i].beat, dir_rows[i].typed, dir_rows[i].want);
            end
        end
        settle();

        configure(1'b1, 24'd999999, 24'd1990, 24'd2010);
        run_phase(220, 0, 0);
        configure(1'b0, 24'hFF_FFFF, 24'd0, 24'hFF_FFFF);
        run_phase(220, 51, 0);
        configure(1'b1, 24'd0, 24'd0, 24'd0);
        run_phase(220, 0, 51);
        lo = 24'($urandom_range(4000));
        configure(1'b1, 24'($urandom), lo, lo + 24'($urandom_range(40)));
        run_phase(220, 9, 9);
        configure(1'b0, 24'd999999, 24'd1990, 24'd2010);
        run_phase(220, 51, 0);
        configure(1'b1, 24'hFF_FFFF, 24'hFF_FFFF, 24'hFF_FFFF);
        run_phase(220, 0, 0);
        configure(1'($urandom), 24'($urandom), 24'($urandom), 24'($urandom));
        run_phase(220, 0, 51);
        configure(1'b0, 24'd5000, 24'd100, 24'd3000);
        run_phase(210, 9, 9);
        repeat (2 * DRAIN_CYCLES) @(negedge clk);

        mismatches += pending_results.size();
        if (mismatches == 0)
            $display("detector_word_timestamp_decoder_top_tb OK");
        else
            $display("detector_word_timestamp_decoder_top_tb NOT OK");
        $finish;
    end

endmodule
